>>> hdl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 engine.
package sha256_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [31:0] t_word;
    typedef logic [7:0][31:0] t_chain;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PAD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN,
        PAD_DONE
    } t_pad;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_INT = 3'd0,
        CFG_IV01    = 3'd1,
        CFG_IV23    = 3'd2,
        CFG_IV45    = 3'd3,
        CFG_IV67    = 3'd4,
        CFG_PRIOR   = 3'd5
    } t_cfg_idx;

    // Sequencer to compression unit.
    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       load;
    } t_core_ctl;

    // Compression unit to sequencer.
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [5:0] fill;
    } t_core_st;

    localparam t_chain STD_IV = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    function automatic t_word rotr(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sig0(t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sig1(t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sig0(t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sig1(t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word round_k(logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

>>> hdl/sha256_core.sv
// Block buffer, message schedule and one-round-per-cycle compression unit.
module sha256_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_core_ctl i_ctl,
    input  sha256_pkg::t_chain    i_iv,
    output sha256_pkg::t_core_st  o_st,
    output sha256_pkg::t_chain    o_chain
);
    import sha256_pkg::*;

    // The block bytes and the schedule share one 16-word shift line.
    t_word      r_sched [16];
    t_chain     r_work;
    t_chain     r_chain;
    logic [5:0] r_fill;
    logic [5:0] r_round;
    logic       r_busy;
    logic       r_fold;

    logic   full_push;
    t_word  n_sched_word;
    t_word  t0;
    t_word  t1;
    t_chain n_work;

    assign full_push = i_ctl.push && (r_fill == 6'd63);

    always_comb begin
        n_sched_word = small_sig1(r_sched[14]) + r_sched[9]
                     + small_sig0(r_sched[1]) + r_sched[0];
        t0 = r_work[7] + big_sig1(r_work[4])
           + (r_work[6] ^ (r_work[4] & (r_work[5] ^ r_work[6])))
           + round_k(r_round) + r_sched[0];
        t1 = big_sig0(r_work[0])
           + (((r_work[0] | r_work[1]) & r_work[2]) | (r_work[0] & r_work[1]));
        n_work[7] = r_work[6];
        n_work[6] = r_work[5];
        n_work[5] = r_work[4];
        n_work[4] = r_work[3] + t0;
        n_work[3] = r_work[2];
        n_work[2] = r_work[1];
        n_work[1] = r_work[0];
        n_work[0] = t0 + t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_round <= '0;
            r_busy  <= 1'b0;
            r_fold  <= 1'b0;
        end else begin
            r_fold <= r_busy && (r_round == 6'd63);
            if (i_ctl.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (full_push) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Shift bytes in while filling; shift words along while running rounds.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            for (int i = 0; i < 15; i++) begin
                r_sched[i] <= {r_sched[i][23:0], r_sched[i+1][31:24]};
            end
            r_sched[15] <= {r_sched[15][23:0], i_ctl.data};
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_sched[i] <= r_sched[i+1];
            end
            r_sched[15] <= n_sched_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (full_push) begin
            r_work <= r_chain;
        end else if (r_busy) begin
            r_work <= n_work;
        end
        if (i_ctl.load) begin
            r_chain <= i_iv;
        end else if (r_fold) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_work[i];
            end
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_fold;
    assign o_st.fill = r_fill;
    assign o_chain   = r_chain;

endmodule

>>> hdl/sha256_hash_engine.sv
// Top level of the SHA-256 engine: configuration, padding sequencer and digest output.
//
// SHA-256 over a byte stream, one byte per input word. A word with i_byte_present
// low carries no byte; a word with i_end_message high closes the message after its
// own byte, appends 0x80, zero fill and the 64-bit big-endian bit length, and then
// presents the eight digest words, index 0 first, o_last_word on index 7. A word is
// taken while the engine is idle; a word that completes a 64-byte block holds o_stall
// while the single round unit runs the 64 rounds and folds the result into the
// chaining value. After the closing word the padder pushes one byte per cycle,
// pausing before the length bytes and while a block is hashed, and runs one or two
// further blocks; the digest then appears as eight output words at the rate the
// receiver takes them. The configuration (standard or intermediate start, chaining
// words, prior byte count) is sampled when the first word of a message is taken;
// write it while the engine is idle. Indexes beyond the prior byte count register
// are ignored.
module sha256_hash_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [sha256_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sha256_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // byte input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_byte_present,
    input  logic                              i_end_message,
    // digest output
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [31:0]                       o_digest_word,
    output logic [2:0]                        o_word_index,
    output logic                              o_last_word
);
    import sha256_pkg::*;

    // configuration
    logic        r_use_int;
    logic [63:0] r_iv [4];
    logic [31:0] r_prior;

    // sequencer
    t_state      r_state, n_state;
    t_pad        r_phase, n_phase;
    logic        r_end, n_end;
    logic        r_open, n_open;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_len, n_len;

    t_core_ctl   core_ctl;
    t_core_st    core_st;
    t_chain      core_chain;
    t_chain      start_iv;
    logic        in_take;
    logic [63:0] len_base;
    logic [5:0]  len_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_int <= 1'b0;
            r_prior   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_iv[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_USE_INT: r_use_int <= i_cfg_data[0];
                CFG_IV01:    r_iv[0]   <= i_cfg_data;
                CFG_IV23:    r_iv[1]   <= i_cfg_data;
                CFG_IV45:    r_iv[2]   <= i_cfg_data;
                CFG_IV67:    r_iv[3]   <= i_cfg_data;
                CFG_PRIOR:   r_prior   <= i_cfg_data[31:0];
                default:     ;  // drop writes to unused indexes
            endcase
        end
    end

    // Starting chaining value: standard IV, or for an intermediate start even words from the upper halves.
    always_comb begin
        start_iv = STD_IV;
        if (r_use_int) begin
            for (int i = 0; i < 4; i++) begin
                start_iv[2*i]   = r_iv[i][63:32];
                start_iv[2*i+1] = r_iv[i][31:0];
            end
        end
    end

    assign in_take   = i_valid && (r_state == S_IDLE);
    assign len_base  = r_open ? r_len : (r_use_int ? {29'd0, r_prior, 3'd0} : 64'd0);
    // Length byte k of the trailer sits at bits 63-8k down.
    assign len_shift = {3'd7 - core_st.fill[2:0], 3'd0};

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_end    = r_end;
        n_open   = r_open;
        n_idx    = r_idx;
        n_len    = r_len;
        core_ctl = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    core_ctl.load = !r_open;
                    core_ctl.push = i_byte_present;
                    core_ctl.data = i_data_byte;
                    n_open  = 1'b1;
                    n_end   = i_end_message;
                    n_phase = PAD_MARK;
                    n_len   = len_base + (i_byte_present ? 64'd8 : 64'd0);
                    if (i_byte_present && core_st.fill == 6'd63) begin
                        n_state = S_HASH;
                    end else if (i_end_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_HASH: begin
                if (core_st.done) begin
                    if (r_phase == PAD_DONE) begin
                        n_state = S_OUT;
                        n_idx   = '0;
                    end else if (r_end) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PAD: begin
                unique case (r_phase)
                    PAD_MARK: begin
                        core_ctl.push = 1'b1;
                        core_ctl.data = 8'h80;
                        n_phase = PAD_ZERO;
                    end
                    PAD_ZERO: begin
                        if (core_st.fill == 6'd56) begin
                            n_phase = PAD_LEN;
                        end else begin
                            core_ctl.push = 1'b1;
                        end
                    end
                    PAD_LEN: begin
                        core_ctl.push = 1'b1;
                        core_ctl.data = 8'(r_len >> len_shift);
                        if (core_st.fill == 6'd63) begin
                            n_phase = PAD_DONE;
                        end
                    end
                    default: ;  // PAD_DONE waits in S_HASH
                endcase
                if (core_ctl.push && core_st.fill == 6'd63) begin
                    n_state = S_HASH;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = S_IDLE;
                        n_open  = 1'b0;
                        n_end   = 1'b0;
                        n_phase = PAD_MARK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PAD_MARK;
            r_end   <= 1'b0;
            r_open  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_end   <= n_end;
            r_open  <= n_open;
            r_idx   <= n_idx;
        end
    end

    // Length is payload: started on the first word of every message and updated on every word taken.
    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    sha256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_iv    (start_iv),
        .o_st    (core_st),
        .o_chain (core_chain)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = core_chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    // The digest is only shown once the compression unit has settled.
    a_out_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !core_st.busy && !core_st.done)
        else $error("digest shown while compression runs");

    // Bytes reach the block buffer only between blocks.
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_ctl.push |-> !core_st.busy && !core_st.done)
        else $error("byte pushed during compression");

    // A digest starts at word 0.
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_word_index == 3'd0)
        else $error("digest did not start at word 0");

    // The last word closes the message and leaves an empty block buffer.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word) |=>
            (r_state == S_IDLE && !r_open && core_st.fill == 6'd0))
        else $error("message not closed after last digest word");

endmodule

>>> verif/sha256_digest_checker.sv
// Digest checker for the SHA-256 engine: tracks configuration, predicts digest words, checks output.
module sha256_digest_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sha256_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sha256_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_byte_present,
    input  logic                              i_end_message,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [31:0]                       o_digest_word,
    input  logic [2:0]                        o_word_index,
    input  logic                              o_last_word,
    output int                                o_errors,
    output int                                o_pending
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } t_digest_word;

    localparam logic [0:7][31:0] START_IV = {
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic         cfg_use_int;
    logic [63:0]  cfg_iv [4];
    logic [31:0]  cfg_prior;

    logic [31:0]  chain [8];
    logic [63:0]  bits_seen;
    logic [7:0]   blk [64];
    int           fill;
    bit           in_message;
    t_digest_word digest_due [$];
    int           shown;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void run_rounds();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] t0, t1, x2, x15;
        int i, r;
        for (i = 0; i < 16; i++) begin
            w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
        end
        for (i = 0; i < 8; i++) begin
            v[i] = chain[i];
        end
        for (r = 0; r < 64; r++) begin
            if (r >= 16) begin
                x2  = w[(r - 2) % 16];
                x15 = w[(r - 15) % 16];
                w[r % 16] = (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10)) + w[(r - 7) % 16]
                          + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w[r % 16];
            end
            t0 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r % 16];
            t1 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t0;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t0 + t1;
        end
        for (i = 0; i < 8; i++) begin
            chain[i] = chain[i] + v[i];
        end
    endfunction

    function automatic void append_byte(logic [7:0] b);
        blk[fill] = b;
        fill++;
        if (fill == 64) begin
            run_rounds();
            fill = 0;
        end
    endfunction

    function automatic void open_message();
        int i;
        if (cfg_use_int) begin
            for (i = 0; i < 4; i++) begin
                chain[2 * i]     = cfg_iv[i][63:32];
                chain[2 * i + 1] = cfg_iv[i][31:0];
            end
            bits_seen = {29'd0, cfg_prior, 3'd0};
        end else begin
            for (i = 0; i < 8; i++) begin
                chain[i] = START_IV[i];
            end
            bits_seen = '0;
        end
        fill = 0;
        in_message = 1'b1;
    endfunction

    // Fold one accepted input word into the running hash; on message end, pad and queue the digest.
    function automatic void absorb_word(logic [7:0] b, logic present, logic closing);
        logic [63:0]  len;
        t_digest_word dw;
        int i;
        if (!in_message) begin
            open_message();
        end
        if (present) begin
            bits_seen = bits_seen + 64'd8;
            append_byte(b);
        end
        if (!closing) begin
            return;
        end
        len = bits_seen;
        append_byte(8'h80);
        while (fill != 56) begin
            append_byte(8'h00);
        end
        for (i = 0; i < 8; i++) begin
            append_byte(len[63 - 8 * i -: 8]);
        end
        for (i = 0; i < 8; i++) begin
            dw.word    = chain[i];
            dw.index   = i[2:0];
            dw.is_last = (i == 7);
            digest_due.push_back(dw);
        end
        in_message = 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_digest_word got, want;
        int i;
        if (!i_rst_n) begin
            cfg_use_int = 1'b0;
            for (i = 0; i < 4; i++) begin
                cfg_iv[i] = '0;
            end
            cfg_prior = '0;
            for (i = 0; i < 8; i++) begin
                chain[i] = START_IV[i];
            end
            for (i = 0; i < 64; i++) begin
                blk[i] = '0;
            end
            bits_seen  = '0;
            fill       = 0;
            in_message = 1'b0;
            digest_due.delete();
            o_errors   = 0;
            shown      = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sha256_pkg::CFG_USE_INT: cfg_use_int = i_cfg_data[0];
                    sha256_pkg::CFG_IV01:    cfg_iv[0]   = i_cfg_data;
                    sha256_pkg::CFG_IV23:    cfg_iv[1]   = i_cfg_data;
                    sha256_pkg::CFG_IV45:    cfg_iv[2]   = i_cfg_data;
                    sha256_pkg::CFG_IV67:    cfg_iv[3]   = i_cfg_data;
                    sha256_pkg::CFG_PRIOR:   cfg_prior   = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            // check the output word before absorbing input taken on the same edge
            if (o_valid && !i_stall) begin
                got = {o_digest_word, o_word_index, o_last_word};
                if (digest_due.size() == 0) begin
                    o_errors++;
                    if (shown < 10) begin
                        shown++;
                        $display("unexpected digest word %h index %0d last %0b",
                                 got.word, got.index, got.is_last);
                    end
                end else begin
                    want = digest_due.pop_front();
                    if (got.word != want.word || got.index != want.index ||
                        got.is_last != want.is_last) begin
                        o_errors++;
                        if (shown < 10) begin
                            shown++;
                            $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                     want.word, want.index, want.is_last,
                                     got.word, got.index, got.is_last);
                        end
                    end
                end
            end
            if (i_valid && !o_stall) begin
                absorb_word(i_data_byte, i_byte_present, i_end_message);
            end
        end
        o_pending = digest_due.size();
    end

endmodule

>>> verif/tb_sha256_hash_engine.sv
// Testbench top for the SHA-256 engine: clock, reset, stimulus, receiver and verdict.
module tb_sha256_hash_engine;

    localparam int LIMIT_CYCLES = 500000;
    // longest closing word: two padding blocks of rounds plus the byte pushes
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 500;
    // indexes that map to no register; writes there must leave everything alone
    localparam logic [sha256_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [sha256_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [sha256_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [sha256_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                              i_valid;
    logic                              o_stall;
    logic [7:0]                        i_data_byte;
    logic                              i_byte_present;
    logic                              i_end_message;
    logic                              o_valid;
    logic                              i_stall;
    logic [31:0]                       o_digest_word;
    logic [2:0]                        o_word_index;
    logic                              o_last_word;

    int errors;
    int pending;
    int cycle_count = 0;
    int items_sent;
    bit no_idle;
    bit hold_req;

    sha256_hash_engine u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_end_message  (i_end_message),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    sha256_digest_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_end_message  (i_end_message),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog: abandon the run if the engine hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one input word and hold it until taken. Called and returns at a falling edge;
    // valid stays high on return so a back-to-back word needs no second assignment.
    task automatic send_word(input logic [7:0] b, input logic present, input logic closing);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= b;
        i_byte_present <= present;
        i_end_message  <= closing;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        @(negedge i_clk);
        items_sent++;
    endtask

    // Send a message of nbytes bytes, sprinkled with empty words; close it either on the
    // last byte or on a trailing empty word.
    task automatic send_message(input int nbytes);
        int  k;
        bit  close_on_byte;
        close_on_byte = (nbytes != 0) && ($urandom_range(0, 3) != 0);
        for (k = 0; k < nbytes; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_word(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (k == nbytes - 1));
        end
        if (!close_on_byte) begin
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Mostly short messages, a good share around the one/two padding block boundary,
    // and now and then a long one; every length is cut to what the phase has left.
    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return $urandom_range(0, 8);
        end
        if (sel < 8) begin
            return $urandom_range(52, 68);
        end
        if (sel == 8) begin
            return $urandom_range(9, 51);
        end
        return $urandom_range(118, 130);
    endfunction

    task automatic random_phase(input int target);
        int first;
        int len;
        first = items_sent;
        while (items_sent - first < target) begin
            len = pick_length();
            // keep the phase close to its word budget
            if (len > target - (items_sent - first)) begin
                len = target - (items_sent - first);
            end
            send_message(len);
        end
    endtask

    // Drop valid, wait for every queued digest word, then let the engine settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sha256_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sha256_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_random_iv();
        write_reg(sha256_pkg::CFG_IV01, {$urandom, $urandom});
        write_reg(sha256_pkg::CFG_IV23, {$urandom, $urandom});
        write_reg(sha256_pkg::CFG_IV45, {$urandom, $urandom});
        write_reg(sha256_pkg::CFG_IV67, {$urandom, $urandom});
        // prior count need not be block aligned; it only feeds the encoded length
        write_reg(sha256_pkg::CFG_PRIOR, {32'd0, $urandom});
    endtask

    // Receiver: draw a stall for each digest word, then wait for the word to be taken.
    // A hold request stretches one stall far enough to back the engine up onto its input.
    initial begin : receiver
        int gap;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = sha256_pkg::CFG_USE_INT;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_data_byte    = '0;
        i_byte_present = 1'b0;
        i_end_message  = 1'b0;
        no_idle        = 1'b0;
        hold_req       = 1'b0;
        items_sent     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Standard start straight out of reset.
        // empty message: hash of no data
        send_word(8'h00, 1'b0, 1'b1);
        // "abc", closed on its last byte
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // extreme bytes with an empty word between them; close on an empty word
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hA5, 1'b0, 1'b1);
        // single byte message
        send_word(8'hFF, 1'b1, 1'b1);
        random_phase(40);
        drain();

        // Intermediate start at the top of every range: all-ones chaining value, largest
        // prior count. Begin with an empty message, which hashes the prior state alone.
        write_reg(sha256_pkg::CFG_USE_INT, 64'd1);
        write_reg(sha256_pkg::CFG_IV01, '1);
        write_reg(sha256_pkg::CFG_IV23, '1);
        write_reg(sha256_pkg::CFG_IV45, '1);
        write_reg(sha256_pkg::CFG_IV67, '1);
        write_reg(sha256_pkg::CFG_PRIOR, 64'h0000_0000_FFFF_FFFF);
        send_word(8'h00, 1'b0, 1'b1);
        random_phase(40);
        drain();

        // All-zero chaining value and no prior bytes; unmapped indexes written with ones
        // must not disturb anything. Neither side idles in this phase.
        write_reg(sha256_pkg::CFG_IV01, '0);
        write_reg(sha256_pkg::CFG_IV23, '0);
        write_reg(sha256_pkg::CFG_IV45, '0);
        write_reg(sha256_pkg::CFG_IV67, '0);
        write_reg(sha256_pkg::CFG_PRIOR, '0);
        write_reg(CFG_UNMAPPED_LO, '1);
        write_reg(CFG_UNMAPPED_HI, '1);
        no_idle = 1'b1;
        random_phase(40);
        drain();
        no_idle = 1'b0;

        // Random chaining value and random prior count, with one long receiver hold-off
        // while the sender keeps offering bytes.
        write_random_iv();
        hold_req = 1'b1;
        random_phase(40);
        drain();

        // Back to the standard start; the chaining words left in place must be ignored.
        write_reg(sha256_pkg::CFG_USE_INT, 64'd0);
        random_phase(40);
        drain();

        // Fresh random intermediate state.
        write_reg(sha256_pkg::CFG_USE_INT, 64'd1);
        write_random_iv();
        random_phase(50);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/sha256_pkg.sv
hdl/sha256_core.sv
hdl/sha256_hash_engine.sv
verif/sha256_digest_checker.sv
verif/tb_sha256_hash_engine.sv
